@@ sv/emo_pkg.sv @@
// Shared constants, state encoding and unit command and result structs for the
// ease-of-movement oscillator. No dependencies; every other file but emo_ram uses it.
package emo_pkg;

   // Field and datapath widths
   localparam int PRICE_BITS    = 32;
   localparam int VOLUME_BITS   = 32;
   localparam int FRACTION_BITS = 16;
   localparam int WINDOW_MAX    = 64;
   localparam int WINDOW_BITS   = 7;
   localparam int OUT_BITS      = 48;

   // Derived widths
   localparam int MID_BITS     = PRICE_BITS + 1;                // high + low
   localparam int PROD_BITS    = MID_BITS + PRICE_BITS;         // change * range
   localparam int DIV_BITS     = PROD_BITS + FRACTION_BITS;     // scaled dividend
   localparam int DEN_BITS     = VOLUME_BITS + 1;               // 2 * volume
   localparam int SUM_BITS     = OUT_BITS + $clog2(WINDOW_MAX); // running sum
   localparam int ADDR_BITS    = $clog2(WINDOW_MAX);
   localparam int RAM_WIDTH    = OUT_BITS + 1;                  // raw value + mark
   localparam int MUL_CNT_BITS = $clog2(PRICE_BITS + 1);
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

   // Constants
   localparam logic [WINDOW_BITS-1:0]  WINDOW_RESET  = WINDOW_BITS'(14);
   localparam logic [OUT_BITS-1:0]     RAW_POS_LIMIT = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0]     RAW_NEG_LIMIT = {1'b1, {(OUT_BITS-1){1'b0}}};
   localparam logic [DIV_CNT_BITS-1:0] RAW_STEPS     = DIV_CNT_BITS'(DIV_BITS);
   localparam logic [DIV_CNT_BITS-1:0] MEAN_STEPS    = DIV_CNT_BITS'(SUM_BITS);

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_SEL,
      ST_MUL,
      ST_DIV,
      ST_UPD,
      ST_ADD,
      ST_ABS,
      ST_MEAN,
      ST_LOAD
   } state_type;

   // Serial multiplier command and result
   typedef struct packed {
      logic                  start;
      logic [MID_BITS-1:0]   multiplicand;
      logic [PRICE_BITS-1:0] multiplier;
   } mul_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [PROD_BITS-1:0] product;
   } mul_res_type;

   // Serial divider command and result
   typedef struct packed {
      logic                    start;
      logic [DIV_BITS-1:0]     dividend;
      logic [DEN_BITS-1:0]     divisor;
      logic [DIV_CNT_BITS-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [OUT_BITS-1:0] quotient;
      logic                overflow;
   } div_res_type;

endpackage

@@ sv/emo_channels.sv @@
// Valid/ready channel interfaces for bars, results and the window register.
// Depends on emo_pkg for field widths.
interface emo_req_if;
   logic                             valid;
   logic                             ready;
   logic [emo_pkg::PRICE_BITS-1:0]   high_price;
   logic [emo_pkg::PRICE_BITS-1:0]   low_price;
   logic [emo_pkg::VOLUME_BITS-1:0]  bar_volume;
   logic                             series_start;

   modport source (output valid, high_price, low_price, bar_volume, series_start,
                   input ready);
   modport sink   (input valid, high_price, low_price, bar_volume, series_start,
                   output ready);
endinterface

interface emo_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [emo_pkg::OUT_BITS-1:0]  average_value;
   logic                          saturated;

   modport source (output valid, average_value, saturated, input ready);
   modport sink   (input valid, average_value, saturated, output ready);
endinterface

interface emo_csr_if;
   logic                             valid;
   logic                             ready;
   logic [emo_pkg::WINDOW_BITS-1:0]  window;

   modport source (output valid, window, input ready);
   modport sink   (input valid, window, output ready);
endinterface

@@ sv/emo_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module emo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/emo_smul.sv @@
// Radix-2 shift-add multiplier: one multiplier bit per cycle.
// Depends on emo_pkg for widths and the command/result structs.
module emo_smul (
   input  logic                 clock,
   input  logic                 reset,
   input  emo_pkg::mul_cmd_type cmd,
   output emo_pkg::mul_res_type res
);

   logic [emo_pkg::PROD_BITS-1:0]    prod_ff, prod_in;
   logic [emo_pkg::MID_BITS-1:0]     mcand_ff, mcand_in;
   logic [emo_pkg::MUL_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [emo_pkg::MID_BITS:0]       partial;

   // Add the multiplicand into the upper half when the low bit is set, then shift
   always_comb begin
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      partial  = {1'b0, prod_ff[emo_pkg::PROD_BITS-1:emo_pkg::PRICE_BITS]}
               + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      if (cmd.start) begin
         mcand_in = cmd.multiplicand;
         prod_in  = {{emo_pkg::MID_BITS{1'b0}}, cmd.multiplier};
         cnt_in   = emo_pkg::MUL_CNT_BITS'(emo_pkg::PRICE_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         prod_in = {partial, prod_ff[emo_pkg::PRICE_BITS-1:1]};
         cnt_in  = cnt_ff - emo_pkg::MUL_CNT_BITS'(1);
         if (cnt_ff == emo_pkg::MUL_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operands
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign res.done    = done_ff;
   assign res.product = prod_ff;

endmodule

@@ sv/emo_sdiv.sv @@
// Restoring divider: one quotient bit per cycle, shared by the raw value
// and the window mean. Depends on emo_pkg for widths and structs.
module emo_sdiv (
   input  logic                 clock,
   input  logic                 reset,
   input  emo_pkg::div_cmd_type cmd,
   output emo_pkg::div_res_type res
);

   logic [emo_pkg::DIV_BITS-1:0]     dvd_ff, dvd_in;
   logic [emo_pkg::DEN_BITS-1:0]     dsr_ff, dsr_in;
   logic [emo_pkg::DEN_BITS-1:0]     rem_ff, rem_in;
   logic [emo_pkg::OUT_BITS-1:0]     quo_ff, quo_in;
   logic                             ovf_ff, ovf_in;
   logic [emo_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [emo_pkg::DEN_BITS:0]       trial;
   logic [emo_pkg::DEN_BITS:0]       diff;
   logic                             fits;

   // Bring down the next dividend bit and subtract where the divisor fits
   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[emo_pkg::DIV_BITS-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = !diff[emo_pkg::DEN_BITS];
      if (cmd.start) begin
         dvd_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
         cnt_in  = cmd.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[emo_pkg::DIV_BITS-2:0], 1'b0};
         rem_in = fits ? diff[emo_pkg::DEN_BITS-1:0] : trial[emo_pkg::DEN_BITS-1:0];
         quo_in = {quo_ff[emo_pkg::OUT_BITS-2:0], fits};
         // a set bit pushed out of the quotient means it does not fit
         ovf_in = ovf_ff | quo_ff[emo_pkg::OUT_BITS-1];
         cnt_in = cnt_ff - emo_pkg::DIV_CNT_BITS'(1);
         if (cnt_ff == emo_pkg::DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = quo_ff;
   assign res.overflow = ovf_ff;

endmodule

@@ sv/ease_of_movement_oscillator_core.sv @@
// Ease-of-movement oscillator top level: sequencer, ring of raw values, running sum.
// Depends on emo_pkg, emo_channels, emo_ram, emo_smul and emo_sdiv.
// Each bar runs a 32-step multiplier and an 81-step raw divider; once the window is full
// a 54-step mean divider follows and a result is loaded. A bar skips the multiplier and
// raw division on zero volume, range or change; a series' first bar gives no result.
// A new bar is taken only in idle, once the last one is through, also while a result waits.
// Reset: clears all history, sets window to 14; ring entries are read only after written.
module ease_of_movement_oscillator_core (
   input  logic             clock,
   input  logic             reset,
   emo_req_if.sink          req_chan,
   emo_rsp_if.source        rsp_chan,
   emo_csr_if.sink          csr_chan
);

   emo_pkg::state_type                state_ff, state_in;
   logic [emo_pkg::WINDOW_BITS-1:0]   window_ff, window_in;
   logic [emo_pkg::WINDOW_BITS-1:0]   w_eff;

   // Bar operands
   logic [emo_pkg::MID_BITS-1:0]      sum_ff, sum_in;
   logic [emo_pkg::PRICE_BITS-1:0]    range_ff, range_in;
   logic [emo_pkg::VOLUME_BITS-1:0]   vol_ff, vol_in;
   logic                              start_ff, start_in;
   logic                              neg_ff, neg_in;
   logic [emo_pkg::MID_BITS-1:0]      mag_ff, mag_in;
   logic [emo_pkg::OUT_BITS-1:0]      raw_ff, raw_in;
   logic                              sat_ff, sat_in;

   // History
   logic [emo_pkg::MID_BITS-1:0]      prev_ff, prev_in;
   logic                              have_prev_ff, have_prev_in;
   logic [emo_pkg::ADDR_BITS-1:0]     pos_ff, pos_in;
   logic [emo_pkg::WINDOW_BITS-1:0]   filled_ff, filled_in;
   logic [emo_pkg::SUM_BITS-1:0]      run_sum_ff, run_sum_in;
   logic [emo_pkg::WINDOW_BITS-1:0]   sat_cnt_ff, sat_cnt_in;

   // Mean and result register
   logic                              mean_neg_ff, mean_neg_in;
   logic [emo_pkg::OUT_BITS-1:0]      quo_ff, quo_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [emo_pkg::OUT_BITS-1:0]      avg_ff, avg_in;
   logic                              rsp_sat_ff, rsp_sat_in;

   // Unit links and ring port
   emo_pkg::mul_cmd_type              mul_cmd;
   emo_pkg::mul_res_type              mul_res;
   emo_pkg::div_cmd_type              div_cmd;
   emo_pkg::div_res_type              div_res;
   logic                              ram_wr_en;
   logic [emo_pkg::RAM_WIDTH-1:0]     ram_rd_data;

   logic                              req_fire;
   logic                              csr_fire;
   logic [emo_pkg::OUT_BITS-1:0]      limit;
   logic [emo_pkg::OUT_BITS-1:0]      raw_mag;
   logic [emo_pkg::SUM_BITS-1:0]      sum_mag;
   logic [emo_pkg::WINDOW_BITS-1:0]   pos_plus;
   logic [emo_pkg::SUM_BITS-1:0]      raw_ext;
   logic [emo_pkg::SUM_BITS-1:0]      old_ext;

   // Handshakes: configuration takes precedence in idle
   assign csr_chan.ready = (state_ff == emo_pkg::ST_IDLE);
   assign req_chan.ready = (state_ff == emo_pkg::ST_IDLE) && !csr_chan.valid;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.average_value = avg_ff;
   assign rsp_chan.saturated     = rsp_sat_ff;

   // Clamp the window into its usable range
   always_comb begin
      if (window_ff == '0) begin
         w_eff = emo_pkg::WINDOW_BITS'(1);
      end else if (window_ff > emo_pkg::WINDOW_BITS'(emo_pkg::WINDOW_MAX)) begin
         w_eff = emo_pkg::WINDOW_BITS'(emo_pkg::WINDOW_MAX);
      end else begin
         w_eff = window_ff;
      end
   end

   assign raw_ext  = {{(emo_pkg::SUM_BITS-emo_pkg::OUT_BITS){raw_ff[emo_pkg::OUT_BITS-1]}},
                      raw_ff};
   assign old_ext  = {{(emo_pkg::SUM_BITS-emo_pkg::OUT_BITS){ram_rd_data[emo_pkg::OUT_BITS-1]}},
                      ram_rd_data[emo_pkg::OUT_BITS-1:0]};
   assign pos_plus = emo_pkg::WINDOW_BITS'(pos_ff) + emo_pkg::WINDOW_BITS'(1);
   assign limit    = neg_ff ? emo_pkg::RAW_NEG_LIMIT : emo_pkg::RAW_POS_LIMIT;
   assign sum_mag  = run_sum_ff[emo_pkg::SUM_BITS-1] ? (~run_sum_ff + 1'b1) : run_sum_ff;
   assign ram_wr_en = (state_ff == emo_pkg::ST_UPD);

   // Sequencer: next state, history updates and unit commands
   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      sum_in       = sum_ff;
      range_in     = range_ff;
      vol_in       = vol_ff;
      start_in     = start_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      raw_in       = raw_ff;
      sat_in       = sat_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      pos_in       = pos_ff;
      filled_in    = filled_ff;
      run_sum_in   = run_sum_ff;
      sat_cnt_in   = sat_cnt_ff;
      mean_neg_in  = mean_neg_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff;
      avg_in       = avg_ff;
      rsp_sat_in   = rsp_sat_ff;
      raw_mag      = div_res.quotient;

      mul_cmd.start        = 1'b0;
      mul_cmd.multiplicand = mag_ff;
      mul_cmd.multiplier   = range_ff;
      div_cmd.start        = 1'b0;
      div_cmd.dividend     = {mul_res.product, {emo_pkg::FRACTION_BITS{1'b0}}};
      div_cmd.divisor      = {vol_ff, 1'b0};
      div_cmd.steps        = emo_pkg::RAW_STEPS;

      // drop the result once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         emo_pkg::ST_IDLE: begin
            if (csr_fire) begin
               window_in    = csr_chan.window;
               prev_in      = '0;
               have_prev_in = 1'b0;
               pos_in       = '0;
               filled_in    = '0;
               run_sum_in   = '0;
               sat_cnt_in   = '0;
            end else if (req_fire) begin
               sum_in   = emo_pkg::MID_BITS'(req_chan.high_price)
                        + emo_pkg::MID_BITS'(req_chan.low_price);
               range_in = (req_chan.high_price > req_chan.low_price)
                        ? (req_chan.high_price - req_chan.low_price) : '0;
               vol_in   = req_chan.bar_volume;
               start_in = req_chan.series_start;
               state_in = emo_pkg::ST_PREP;
            end
         end
         emo_pkg::ST_PREP: begin
            prev_in = sum_ff;
            if (start_ff || !have_prev_ff) begin
               // first bar of a series only becomes the previous bar
               have_prev_in = 1'b1;
               if (start_ff) begin
                  pos_in     = '0;
                  filled_in  = '0;
                  run_sum_in = '0;
                  sat_cnt_in = '0;
               end
               state_in = emo_pkg::ST_IDLE;
            end else begin
               neg_in   = sum_ff < prev_ff;
               mag_in   = (sum_ff < prev_ff) ? (prev_ff - sum_ff) : (sum_ff - prev_ff);
               state_in = emo_pkg::ST_SEL;
            end
         end
         emo_pkg::ST_SEL: begin
            if (vol_ff == '0) begin
               sat_in   = 1'b1;
               raw_in   = (mag_ff == '0) ? '0 : limit;
               state_in = emo_pkg::ST_UPD;
            end else if (range_ff == '0 || mag_ff == '0) begin
               sat_in   = 1'b0;
               raw_in   = '0;
               state_in = emo_pkg::ST_UPD;
            end else begin
               mul_cmd.start = 1'b1;
               state_in      = emo_pkg::ST_MUL;
            end
         end
         emo_pkg::ST_MUL: begin
            if (mul_res.done) begin
               div_cmd.start = 1'b1;
               state_in      = emo_pkg::ST_DIV;
            end
         end
         emo_pkg::ST_DIV: begin
            if (div_res.done) begin
               // saturate a quotient beyond the signed output range
               if (div_res.overflow || div_res.quotient > limit) begin
                  raw_mag = limit;
                  sat_in  = 1'b1;
               end else begin
                  sat_in  = 1'b0;
               end
               raw_in   = neg_ff ? (~raw_mag + 1'b1) : raw_mag;
               state_in = emo_pkg::ST_UPD;
            end
         end
         emo_pkg::ST_UPD: begin
            // retire the oldest entry once the window is full
            if (filled_ff == w_eff) begin
               run_sum_in = run_sum_ff - old_ext;
               if (ram_rd_data[emo_pkg::OUT_BITS] && sat_cnt_ff != '0) begin
                  sat_cnt_in = sat_cnt_ff - emo_pkg::WINDOW_BITS'(1);
               end
            end else begin
               filled_in = filled_ff + emo_pkg::WINDOW_BITS'(1);
            end
            state_in = emo_pkg::ST_ADD;
         end
         emo_pkg::ST_ADD: begin
            run_sum_in = run_sum_ff + raw_ext;
            if (sat_ff) begin
               sat_cnt_in = sat_cnt_ff + emo_pkg::WINDOW_BITS'(1);
            end
            pos_in   = (pos_plus >= w_eff) ? '0 : pos_plus[emo_pkg::ADDR_BITS-1:0];
            state_in = (filled_ff == w_eff) ? emo_pkg::ST_ABS : emo_pkg::ST_IDLE;
         end
         emo_pkg::ST_ABS: begin
            mean_neg_in      = run_sum_ff[emo_pkg::SUM_BITS-1];
            div_cmd.start    = 1'b1;
            div_cmd.dividend = {sum_mag, {(emo_pkg::DIV_BITS-emo_pkg::SUM_BITS){1'b0}}};
            div_cmd.divisor  = {{(emo_pkg::DEN_BITS-emo_pkg::WINDOW_BITS){1'b0}}, w_eff};
            div_cmd.steps    = emo_pkg::MEAN_STEPS;
            state_in         = emo_pkg::ST_MEAN;
         end
         emo_pkg::ST_MEAN: begin
            if (div_res.done) begin
               quo_in   = div_res.quotient;
               state_in = emo_pkg::ST_LOAD;
            end
         end
         emo_pkg::ST_LOAD: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               avg_in       = mean_neg_ff ? (~quo_ff + 1'b1) : quo_ff;
               rsp_sat_in   = (sat_cnt_ff != '0);
               state_in     = emo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = emo_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and history registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= emo_pkg::ST_IDLE;
         window_ff    <= emo_pkg::WINDOW_RESET;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         pos_ff       <= '0;
         filled_ff    <= '0;
         run_sum_ff   <= '0;
         sat_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         pos_ff       <= pos_in;
         filled_ff    <= filled_in;
         run_sum_ff   <= run_sum_in;
         sat_cnt_ff   <= sat_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      range_ff    <= range_in;
      vol_ff      <= vol_in;
      start_ff    <= start_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      raw_ff      <= raw_in;
      sat_ff      <= sat_in;
      mean_neg_ff <= mean_neg_in;
      quo_ff      <= quo_in;
      avg_ff      <= avg_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   // Ring of raw values with their saturation marks
   emo_ram #(
      .WIDTH (emo_pkg::RAM_WIDTH),
      .DEPTH (emo_pkg::WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_ff),
      .wr_data ({sat_ff, raw_ff}),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   emo_smul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .res   (mul_res)
   );

   emo_sdiv u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

endmodule
